/* hdl/tls_rst_pkg.sv */
// tls_rst_pkg: shared types, codes and helpers of the tls record sequence tracker
// depends on nothing; imported by tls_rst_cell and tls_record_sequence_tracker
package tls_rst_pkg;

	localparam int unsigned RecordDepthDefault = 64;
	localparam int unsigned SeqW = 32;
	localparam int unsigned LenW = 15;
	localparam int unsigned RecNumW = 64;
	localparam logic [LenW-1:0] MaxRecordLen = 15'd16413;

	// request kinds
	typedef enum logic [1:0] {
		REQ_START  = 2'd0,
		REQ_PUSH   = 2'd1,
		REQ_ACK    = 2'd2,
		REQ_LOOKUP = 2'd3
	} req_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_MISS     = 2'd1,
		ST_FULL     = 2'd2,
		ST_LEN_ERR  = 2'd3
	} status_t;

	// one stored record
	typedef struct packed {
		logic [SeqW-1:0] end_seq;
		logic [LenW-1:0] len;
	} entry_t;

	// control from the sequencer to each cell
	typedef struct packed {
		logic   rotate;
		entry_t wr_data;
	} cell_ctl_t;

	// a is before b modulo 2^32
	function automatic logic seq_before(input logic [SeqW-1:0] a, input logic [SeqW-1:0] b);
		logic [SeqW-1:0] d;
		d = a - b;
		return d[SeqW-1];
	endfunction

endpackage

/* hdl/tls_record_sequence_tracker.sv */
// tls_record_sequence_tracker: top level, request sequencer over a chain of record cells
// depends on tls_rst_pkg and tls_rst_cell
//
// channel | dir | handshake          | payload
// s_*     | in  | s_tvalid/s_tready  | s_tdata seq, record_len; s_tuser req_type
// m_*     | out | m_tvalid/m_tready  | m_tdata end, len, record number; m_tuser status
// cfg_*   | in  | cfg_valid/cfg_ready| cfg_data initial_record_number
//
// start and push answer straight from idle; ack pops every covered head record, one pop per cycle
// lookup rotates the cell chain once all the way round
// reset clears control state only; cell contents are undefined until written
// a finished result waits in the output register; a new request is taken when it drains
module tls_record_sequence_tracker #(
	parameter int unsigned RECORD_DEPTH = tls_rst_pkg::RecordDepthDefault
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [47:0]   s_tdata,   // [31:0] seq, [46:32] record_len, [47] zero
	input  logic [1:0]    s_tuser,   // [1:0] req_type
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [111:0]  m_tdata,   // [31:0] found_end_seq, [46:32] found_len,
	                                 // [110:47] found_record_number, [111] zero
	output logic [1:0]    m_tuser,   // [1:0] status
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [63:0]   cfg_data   // initial_record_number
);
	import tls_rst_pkg::*;

	localparam int unsigned CW = $clog2(RECORD_DEPTH + 1);
	localparam int unsigned IW = $clog2(RECORD_DEPTH);
	localparam logic [CW-1:0] DepthC = CW'(RECORD_DEPTH);
	localparam logic [IW-1:0] LastIdx = IW'(RECORD_DEPTH - 1);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_ACK  = 3'b010,
		S_LOOK = 3'b100
	} state_t;

	state_t              state_q;
	logic [CW-1:0]       count_q;
	logic [RecNumW-1:0]  oldest_q;
	logic [RecNumW-1:0]  init_rn_q;
	logic                hint_valid_q;
	logic [IW-1:0]       hint_off_q;
	entry_t              hint_entry_q;
	logic [SeqW-1:0]     seq_q;
	logic [IW-1:0]       idx_q;
	logic [IW-1:0]       start_q;
	logic                found_q;
	logic                out_valid_q;
	status_t             out_status_q;
	entry_t              out_entry_q;
	logic [RecNumW-1:0]  out_rn_q;

	entry_t              cells [RECORD_DEPTH];
	cell_ctl_t           ctl;
	logic [RECORD_DEPTH-1:0] wr_en;

	logic [SeqW-1:0]     in_seq;
	logic [LenW-1:0]     in_len;
	req_t                in_req;
	logic                in_fire;
	logic                pop;
	logic                hit;
	logic                hint_ok;
	logic [SeqW-1:0]     hint_start;

	assign in_seq  = s_tdata[31:0];
	assign in_len  = s_tdata[46:32];
	assign in_req  = req_t'(s_tuser);
	assign s_tready = (state_q == S_IDLE) && (!out_valid_q || m_tready);
	assign in_fire = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	assign hint_start = hint_entry_q.end_seq - SeqW'(hint_entry_q.len);
	assign hint_ok = hint_valid_q && !seq_before(in_seq, hint_start);

	// head record is covered by the ack
	assign pop = (state_q == S_ACK) && (count_q != '0) && !seq_before(seq_q, cells[0].end_seq);
	// record at the head of the rotation ends after the query
	assign hit = (state_q == S_LOOK) && !found_q && (idx_q >= start_q)
		&& (CW'(idx_q) < count_q)
		&& seq_before(seq_q, cells[0].end_seq);

	// cell control
	always_comb begin
		ctl.rotate = pop || (state_q == S_LOOK);
		ctl.wr_data.end_seq = in_seq + SeqW'(in_len);
		ctl.wr_data.len = in_len;
		if (in_req == REQ_START) begin
			ctl.wr_data.end_seq = in_seq;
			ctl.wr_data.len = '0;
		end
	end

	// the chain of cells
	for (genvar k = 0; k < RECORD_DEPTH; k++) begin : g_cell
		localparam int unsigned Nxt = (k == RECORD_DEPTH - 1) ? 0 : k + 1;
		assign wr_en[k] = in_fire && (
			(in_req == REQ_START && k == 0) ||
			(in_req == REQ_PUSH && in_len <= MaxRecordLen && count_q < DepthC
				&& count_q == CW'(k)));
		tls_rst_cell u_cell (
			.clk   (clk),
			.ctl   (ctl),
			.wr_en (wr_en[k]),
			.nxt   (cells[Nxt]),
			.cur   (cells[k])
		);
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_rn_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			init_rn_q <= cfg_data;
		end
	end

	// request sequencer and ring bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			oldest_q     <= '0;
			hint_valid_q <= 1'b0;
			hint_off_q   <= '0;
			hint_entry_q <= '0;
			seq_q        <= '0;
			out_valid_q  <= 1'b0;
			out_status_q <= ST_OK;
			out_entry_q  <= '0;
			out_rn_q     <= '0;
			found_q      <= 1'b0;
			idx_q        <= '0;
			start_q      <= '0;
		end else begin
			if (m_tvalid && m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						seq_q <= in_seq;
						out_entry_q <= '0;
						out_rn_q <= '0;
						out_status_q <= ST_OK;
						case (in_req)
							REQ_START: begin
								count_q <= CW'(1);
								oldest_q <= init_rn_q - RecNumW'(1);
								hint_valid_q <= 1'b0;
								hint_off_q <= '0;
								out_valid_q <= 1'b1;
							end
							REQ_PUSH: begin
								out_valid_q <= 1'b1;
								if (in_len > MaxRecordLen) begin
									out_status_q <= ST_LEN_ERR;
								end else if (count_q >= DepthC) begin
									out_status_q <= ST_FULL;
								end else begin
									count_q <= count_q + CW'(1);
								end
							end
							REQ_ACK: begin
								if (hint_valid_q && !seq_before(in_seq, hint_entry_q.end_seq)) begin
									hint_valid_q <= 1'b0;
								end
								state_q <= S_ACK;
							end
							default: begin
								idx_q <= '0;
								found_q <= 1'b0;
								start_q <= hint_ok ? hint_off_q : '0;
								state_q <= S_LOOK;
							end
						endcase
					end
				end
				S_ACK: begin
					if (pop) begin
						count_q <= count_q - CW'(1);
						oldest_q <= oldest_q + RecNumW'(1);
						if (hint_off_q == '0) begin
							hint_valid_q <= 1'b0;
						end else begin
							hint_off_q <= hint_off_q - IW'(1);
						end
					end else begin
						out_status_q <= ST_OK;
						out_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_LOOK: begin
					if (hit) begin
						found_q <= 1'b1;
						out_entry_q <= cells[0];
						out_rn_q <= oldest_q + RecNumW'(idx_q);
						if (!hint_valid_q || seq_before(hint_entry_q.end_seq, cells[0].end_seq)) begin
							hint_valid_q <= 1'b1;
							hint_off_q <= idx_q;
							hint_entry_q <= cells[0];
						end
					end
					idx_q <= idx_q + IW'(1);
					if (idx_q == LastIdx) begin
						out_status_q <= (found_q || hit) ? ST_OK : ST_MISS;
						out_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {1'b0, out_rn_q, out_entry_q.len, out_entry_q.end_seq};

	// ring never holds more records than cells
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DepthC) else $error("record count above depth");

	// a valid hint points inside the held records
	a_hint_inside: assert property (@(posedge clk) disable iff (!arst_n)
		hint_valid_q |-> (CW'(hint_off_q) < count_q)) else $error("hint outside ring");

	// no request is taken while an ack or lookup is at work
	a_busy_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !s_tready) else $error("request taken while busy");

	// a lookup ends after exactly one full rotation
	a_look_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LOOK && idx_q == LastIdx) |=> (state_q == S_IDLE && out_valid_q))
		else $error("lookup did not finish");

endmodule

/* hdl/tls_rst_cell.sv */
// tls_rst_cell: one record slot of the ring chain
// depends on tls_rst_pkg
module tls_rst_cell (
	input  logic                  clk,
	input  tls_rst_pkg::cell_ctl_t ctl,
	input  logic                  wr_en,
	input  tls_rst_pkg::entry_t   nxt,
	output tls_rst_pkg::entry_t   cur
);
	import tls_rst_pkg::*;

	entry_t entry_q;

	// rotate from the neighbor, else take a write
	always_ff @(posedge clk) begin
		if (ctl.rotate) begin
			entry_q <= nxt;
		end else if (wr_en) begin
			entry_q <= ctl.wr_data;
		end
	end

	assign cur = entry_q;

endmodule
